FILE: sv/vmpa_pkg.sv
// ----------------------------------------------------------------------------
// vmpa_pkg: shared types and constants for the video memory port
// Item, result and command types, action codes, back-end states.
// ----------------------------------------------------------------------------
package vmpa_pkg;

  localparam int VMPA_NT_BYTES   = 2048;
  localparam int VMPA_NT_IDX_W   = $clog2(VMPA_NT_BYTES);
  localparam int VMPA_PAL_BYTES  = 32;
  localparam int VMPA_PAL_IDX_W  = $clog2(VMPA_PAL_BYTES);
  localparam int VMPA_ADDR_W     = 14;
  localparam int VMPA_PADDR_W    = 13;
  localparam int VMPA_CMD_DEPTH  = 2;
  localparam int VMPA_OUT_DEPTH  = 2;
  localparam int VMPA_STEP_BIT   = 2;

  localparam logic [2:0] ACT_CTRL  = 3'd0;
  localparam logic [2:0] ACT_ADDR  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_LOAD  = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              read_data;
    logic                    pattern_request;
    logic [VMPA_PADDR_W-1:0] pattern_address;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_NT_WR,
    CMD_PAL_WR,
    CMD_NT_RD,
    CMD_PAL_RD,
    CMD_PAT_RD,
    CMD_BUF_RD,
    CMD_LOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [VMPA_NT_IDX_W-1:0] index;
    logic [7:0]               data;
    logic [VMPA_PADDR_W-1:0]  paddr;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_FILL
  } back_state_t;

endpackage

FILE: sv/vmpa_fifo.sv
// ----------------------------------------------------------------------------
// vmpa_fifo: small register queue
// Flop-based FIFO with push/full and pop/empty; head is shown combinationally.
// ----------------------------------------------------------------------------
module vmpa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/vmpa_front.sv
// ----------------------------------------------------------------------------
// vmpa_front: access decoder
// Holds control, address latch and mirroring; turns each access into a
// memory command with a folded index.
// ----------------------------------------------------------------------------
module vmpa_front import vmpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  logic [7:0]             ctrl_r, ctrl_nxt;
  logic [VMPA_ADDR_W-1:0] addr_r, addr_nxt, addr_step;
  logic                   latch_low_r, latch_low_nxt;
  logic                   mirror_v_r;
  logic [VMPA_NT_IDX_W-1:0]  nt_idx;
  logic [VMPA_PAL_IDX_W-1:0] pal_idx;
  logic                   in_nt, in_pal, in_pat;

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  assign in_pat = !addr_r[13];
  assign in_nt  = (addr_r[13:12] == 2'b10);
  assign in_pal = (addr_r[13:8] == 6'h3F);

  assign addr_step = addr_r + (ctrl_r[VMPA_STEP_BIT] ? VMPA_ADDR_W'(32) : VMPA_ADDR_W'(1));

  // horizontal: tables 0/1 and 2/3 share; vertical: 0/2 and 1/3 share
  assign nt_idx = mirror_v_r ? addr_r[10:0] : {addr_r[11], addr_r[9:0]};

  // sprite backdrop entries fold onto the background ones
  always_comb begin
    pal_idx = addr_r[4:0];
    if (addr_r[4] && addr_r[1:0] == 2'b00) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_comb begin
    ctrl_nxt      = ctrl_r;
    addr_nxt      = addr_r;
    latch_low_nxt = latch_low_r;
    cmd.kind      = CMD_NOP;
    cmd.index     = in_pal ? VMPA_NT_IDX_W'(pal_idx) : nt_idx;
    cmd.data      = in_item.data_byte;
    cmd.paddr     = addr_r[VMPA_PADDR_W-1:0];
    case (in_item.action)
      ACT_CTRL: begin
        ctrl_nxt = in_item.data_byte;
      end
      ACT_ADDR: begin
        if (!latch_low_r) begin
          addr_nxt = {in_item.data_byte[5:0], addr_r[7:0]};
        end else begin
          addr_nxt = {addr_r[13:8], in_item.data_byte};
        end
        latch_low_nxt = !latch_low_r;
      end
      ACT_WRITE: begin
        addr_nxt = addr_step;
        if (in_nt) begin
          cmd.kind = CMD_NT_WR;
        end else if (in_pal) begin
          cmd.kind = CMD_PAL_WR;
        end
      end
      ACT_READ: begin
        addr_nxt = addr_step;
        if (in_pat) begin
          cmd.kind = CMD_PAT_RD;
        end else if (in_nt) begin
          cmd.kind = CMD_NT_RD;
        end else if (in_pal) begin
          cmd.kind = CMD_PAL_RD;
        end else begin
          cmd.kind = CMD_BUF_RD;
        end
      end
      ACT_LOAD: begin
        cmd.kind = CMD_LOAD;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      addr_r      <= '0;
      latch_low_r <= 1'b0;
      mirror_v_r  <= 1'b0;
    end else begin
      if (cmd_push) begin
        ctrl_r      <= ctrl_nxt;
        addr_r      <= addr_nxt;
        latch_low_r <= latch_low_nxt;
      end
      if (cfg_we) begin
        mirror_v_r <= cfg_wdata;
      end
    end
  end

endmodule

FILE: sv/vmpa_back.sv
// ----------------------------------------------------------------------------
// vmpa_back: memory executor
// Runs commands against name-table and palette memory, keeps the read
// buffer and emits one result per command.
// ----------------------------------------------------------------------------
module vmpa_back import vmpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  back_state_t state_r, state_nxt;
  logic [7:0]  buf_r;
  logic        fill_pal_r;
  logic [7:0]  nt_rdata_r, pal_rdata_r;
  logic [7:0]  nt_mem_r  [VMPA_NT_BYTES];
  logic [7:0]  pal_mem_r [VMPA_PAL_BYTES];
  logic        go;
  logic        nt_we, nt_re, pal_we, pal_re;

  assign go = (state_r == BK_IDLE) && !cmd_empty && !res_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (go && (cmd.kind == CMD_NT_RD || cmd.kind == CMD_PAL_RD)) begin
          state_nxt = BK_FILL;
        end
      end
      BK_FILL: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop  = go;
    res_push = go;
    nt_we    = go && (cmd.kind == CMD_NT_WR);
    pal_we   = go && (cmd.kind == CMD_PAL_WR);
    nt_re    = go && (cmd.kind == CMD_NT_RD);
    pal_re   = go && (cmd.kind == CMD_PAL_RD);
    res.read_data       = '0;
    res.pattern_request = 1'b0;
    res.pattern_address = '0;
    case (cmd.kind)
      CMD_NT_RD, CMD_PAL_RD, CMD_BUF_RD: begin
        res.read_data = buf_r;
      end
      CMD_PAT_RD: begin
        res.read_data       = buf_r;
        res.pattern_request = 1'b1;
        res.pattern_address = cmd.paddr;
      end
      default: begin
        res.read_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      buf_r      <= '0;
      fill_pal_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        fill_pal_r <= (cmd.kind == CMD_PAL_RD);
        if (cmd.kind == CMD_LOAD) begin
          buf_r <= cmd.data;
        end
      end
      // refill the buffer from the registered memory read
      if (state_r == BK_FILL) begin
        buf_r <= fill_pal_r ? pal_rdata_r : nt_rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem_r[cmd.index] <= cmd.data;
    end
    if (nt_re) begin
      nt_rdata_r <= nt_mem_r[cmd.index];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem_r[cmd.index[VMPA_PAL_IDX_W-1:0]] <= cmd.data;
    end
    if (pal_re) begin
      pal_rdata_r <= pal_mem_r[cmd.index[VMPA_PAL_IDX_W-1:0]];
    end
  end

endmodule

FILE: sv/video_memory_port_access_top.sv
// ----------------------------------------------------------------------------
// video_memory_port_access_top: CPU-side video memory data port
// Control, two-write address latch, buffered data reads and writes with
// name-table mirroring and palette folding.
// ----------------------------------------------------------------------------
// Each accepted beat yields exactly one result beat, in order. The decoder
// takes a beat every cycle while its command queue has room; the executor
// takes a command when idle and the result queue has room; a name-table or
// palette read goes through BK_FILL, as the memory read is registered before
// it refills the read buffer. A read returns the previous buffer; a
// pattern-region read raises pattern_request and a later pattern-return beat
// loads the buffer. Write mirror_vertical only while the block is idle.
module video_memory_port_access_top import vmpa_pkg::*; #(
  parameter int CMD_DEPTH = VMPA_CMD_DEPTH,
  parameter int OUT_DEPTH = VMPA_OUT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  cmd_t      cmd_in, cmd_out;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  out_item_t res;
  logic      res_push, res_full;

  vmpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  vmpa_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  vmpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  vmpa_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

FILE: tb/sv/video_memory_port_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_memory_port_access_checker: result checker for the video memory port
// Follows every accepted input beat with its own copy of the port state
// (control byte, address latch, read buffer, name table and palette memory)
// and compares each accepted result beat with the oldest expected answer.
// ----------------------------------------------------------------------------
module video_memory_port_access_checker import vmpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam logic [5:0] PAL_PAGE = 6'h3F;
  localparam logic [1:0] NT_AREA  = 2'b10;

  logic                   mirror_v;
  logic [7:0]             ctrl_byte;
  logic [VMPA_ADDR_W-1:0] vaddr;
  logic                   low_next;
  logic [7:0]             rd_buf;
  logic [7:0]             nt_mem  [VMPA_NT_BYTES];
  logic [7:0]             pal_mem [VMPA_PAL_BYTES];
  out_item_t              answers_due [$];
  int                     fails;

  // Fold a name-table address into the 2 KiB store.
  function automatic logic [VMPA_NT_IDX_W-1:0] nt_slot(input logic [VMPA_ADDR_W-1:0] a);
    if (mirror_v) begin
      return a[10:0];
    end
    return {a[11], a[9:0]};
  endfunction

  // Entries 0x10, 0x14, 0x18 and 0x1C share storage with the background ones.
  function automatic logic [VMPA_PAL_IDX_W-1:0] pal_slot(input logic [VMPA_ADDR_W-1:0] a);
    logic [VMPA_PAL_IDX_W-1:0] p;
    p = a[VMPA_PAL_IDX_W-1:0];
    if (p[4] && p[1:0] == 2'b00) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

  function automatic logic [VMPA_ADDR_W-1:0] stepped(input logic [VMPA_ADDR_W-1:0] a);
    return a + (ctrl_byte[VMPA_STEP_BIT] ? VMPA_ADDR_W'(32) : VMPA_ADDR_W'(1));
  endfunction

  task automatic port_access(input in_item_t it, output out_item_t ans);
    logic [VMPA_ADDR_W-1:0] a;
    a = vaddr;
    ans = '0;
    case (it.action)
      ACT_CTRL: begin
        ctrl_byte = it.data_byte;
      end
      ACT_ADDR: begin
        if (!low_next) begin
          vaddr = {it.data_byte[5:0], a[7:0]};
        end else begin
          vaddr = {a[13:8], it.data_byte};
        end
        low_next = ~low_next;
      end
      ACT_WRITE: begin
        vaddr = stepped(a);
        if (a[13:12] == NT_AREA) begin
          nt_mem[nt_slot(a)] = it.data_byte;
        end else if (a[13:8] == PAL_PAGE) begin
          pal_mem[pal_slot(a)] = it.data_byte;
        end
      end
      ACT_READ: begin
        ans.read_data = rd_buf;
        vaddr = stepped(a);
        if (!a[13]) begin
          ans.pattern_request = 1'b1;
          ans.pattern_address = a[VMPA_PADDR_W-1:0];
        end else if (a[13:12] == NT_AREA) begin
          rd_buf = nt_mem[nt_slot(a)];
        end else if (a[13:8] == PAL_PAGE) begin
          rd_buf = pal_mem[pal_slot(a)];
        end
      end
      ACT_LOAD: begin
        rd_buf = it.data_byte;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t ans;
    if (!rst_n) begin
      mirror_v  = 1'b0;
      ctrl_byte = '0;
      vaddr     = '0;
      low_next  = 1'b0;
      rd_buf    = '0;
      for (int i = 0; i < VMPA_NT_BYTES; i++) nt_mem[i] = '0;
      for (int i = 0; i < VMPA_PAL_BYTES; i++) pal_mem[i] = '0;
      answers_due.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        mirror_v = cfg_wdata;
      end
      // Compare before queuing: a result at this edge stems from an older beat.
      if (out_pop && !out_empty) begin
        if (answers_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: rd=%h req=%b pa=%h",
                     out_item.read_data, out_item.pattern_request, out_item.pattern_address);
          end
        end else begin
          want = answers_due.pop_front();
          if (want.read_data !== out_item.read_data ||
              want.pattern_request !== out_item.pattern_request ||
              want.pattern_address !== out_item.pattern_address) begin
            fails++;
            if (fails <= 10) begin
              $display("result mismatch: exp rd=%h req=%b pa=%h, got rd=%h req=%b pa=%h",
                       want.read_data, want.pattern_request, want.pattern_address,
                       out_item.read_data, out_item.pattern_request, out_item.pattern_address);
            end
          end
        end
      end
      if (in_push && !in_full) begin
        port_access(in_item, ans);
        answers_due.push_back(ans);
      end
    end
    fail_count <= fails;
    pending    <= answers_due.size();
  end

endmodule

FILE: tb/sv/video_memory_port_access_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_memory_port_access_top_test: stimulus for the video memory port
// Preloads the name-table windows and the palette that the accesses use, runs
// directed accesses, then random access sequences under three idling profiles
// and both mirroring modes.
// ----------------------------------------------------------------------------
module video_memory_port_access_top_test import vmpa_pkg::*; ();

  localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         RANDOM_BEATS   = 370;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_push   = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_item;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 19;
  int   recv_idle_pct = 57;
  logic hold_go       = 1'b0;
  logic hold_taken    = 1'b0;
  int   hold_left     = 0;
  logic addr_low_next = 1'b0;
  int   beats_sent    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  video_memory_port_access_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  video_memory_port_access_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_item    (in_item),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random pops, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_pop    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_beat(input logic [2:0] act, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{action: act, data_byte: b};
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (act == ACT_ADDR) begin
      addr_low_next = ~addr_low_next;
    end
    beats_sent++;
  endtask

  task automatic set_address(input logic [VMPA_ADDR_W-1:0] a);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    // Realign the latch first if a lone address write left it half way.
    if (addr_low_next) begin
      push_beat(ACT_ADDR, 8'($urandom_range(0, 255)));
    end
    push_beat(ACT_ADDR, {junk, a[13:8]});
    push_beat(ACT_ADDR, a[7:0]);
  endtask

  task automatic settle;
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mirror(input logic v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_run(input int count);
    int                     stop;
    int                     kind;
    int                     region;
    int                     n;
    logic [VMPA_ADDR_W-1:0] a;
    logic [2:0]             act;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        push_beat(ACT_CTRL, 8'($urandom_range(0, 255)));
      end else if (kind < 16) begin
        // No reads or writes here, so data accesses stay on the addressed runs below.
        repeat ($urandom_range(1, 3)) begin
          act = 3'($urandom_range(0, 5));
          if (act >= ACT_WRITE) begin
            act = act + 3'd2;
          end
          push_beat(act, 8'($urandom_range(0, 255)));
        end
      end else if (kind < 20) begin
        push_beat(ACT_ADDR, 8'($urandom_range(0, 255)));
      end else begin
        region = $urandom_range(0, 3);
        case (region)
          0:       a = 14'($urandom_range(14'h0000, 14'h1FFF));
          // Low 64 bytes of any table: six steps of 32 stay in the preloaded windows.
          1:       a = {2'b10, 2'($urandom_range(0, 3)), 4'b0000, 6'($urandom_range(0, 63))};
          2:       a = 14'($urandom_range(14'h3000, 14'h3EFF));
          default: a = 14'($urandom_range(14'h3F00, 14'h3FFF));
        endcase
        // Sit on the top of a region now and then so the step crosses it.
        if ($urandom_range(0, 9) == 0) begin
          case (region)
            0:       a = 14'h1FFF;
            1:       a = 14'h2FFF;
            2:       a = 14'h3EFF;
            default: a = 14'h3FFF;
          endcase
        end
        set_address(a);
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            push_beat(ACT_WRITE, 8'($urandom_range(0, 255)));
          end else begin
            push_beat(ACT_READ, 8'($urandom_range(0, 255)));
            if (region == 0 && $urandom_range(0, 3) != 0) begin
              push_beat(ACT_LOAD, 8'($urandom_range(0, 255)));
            end
          end
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the name-table windows, the last entry and the palette before any read.
    set_mirror(1'b1);
    push_beat(ACT_CTRL, 8'h00);
    set_address(14'h2000);
    repeat (256) push_beat(ACT_WRITE, 8'($urandom_range(0, 255)));
    set_address(14'h2400);
    repeat (256) push_beat(ACT_WRITE, 8'($urandom_range(0, 255)));
    set_address(14'h27FF);
    push_beat(ACT_WRITE, 8'($urandom_range(0, 255)));
    set_address(14'h3F00);
    repeat (VMPA_PAL_BYTES) push_beat(ACT_WRITE, 8'($urandom_range(0, 255)));

    // Directed accesses under horizontal mirroring.
    set_mirror(1'b0);
    push_beat(ACT_CTRL, 8'h00);
    set_address(14'h2000);
    push_beat(ACT_WRITE, 8'hFF);
    set_address(14'h2400);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'hFF);
    push_beat(ACT_CTRL, 8'hFF);
    push_beat(ACT_ADDR, 8'hFF);
    push_beat(ACT_ADDR, 8'h10);
    push_beat(ACT_WRITE, 8'hAA);
    push_beat(ACT_READ, 8'h00);
    set_address(14'h3FE0);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_LOAD, 8'h5A);
    push_beat(ACT_CTRL, 8'h00);
    set_address(14'h1FFF);
    push_beat(ACT_READ, 8'h00);
    set_address(14'h3EFF);
    push_beat(ACT_READ, 8'h00);
    for (int k = ACT_RSVD_FIRST; k <= ACT_RSVD_LAST; k++) push_beat(3'(k), 8'hFF);
    push_beat(ACT_LOAD, 8'h00);

    set_mirror(1'b1);
    random_run(RANDOM_BEATS);

    send_idle_pct = 57;
    recv_idle_pct = 19;
    set_mirror(1'b0);
    random_run(RANDOM_BEATS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mirror(1'b1);
    hold_go <= 1'b1;
    random_run(RANDOM_BEATS);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/vmpa_pkg.sv
sv/vmpa_fifo.sv
sv/vmpa_front.sv
sv/vmpa_back.sv
sv/video_memory_port_access_top.sv
tb/sv/video_memory_port_access_checker.sv
tb/sv/video_memory_port_access_top_test.sv
